### hw/rtl/ule_pkg.sv
// ----------------------------------------------------------------------------
// ule_pkg
// Shared types and constants for the UTF-16 line ending converter.
// ----------------------------------------------------------------------------
package ule_pkg;

    localparam logic [15:0] MARK_SWAPPED = 16'hFFFE;
    localparam logic [15:0] LF_CODE      = 16'h000A;
    localparam logic [15:0] CR_CODE      = 16'h000D;

    localparam logic [1:0] ENDING_LF   = 2'd0;
    localparam logic [1:0] ENDING_CR   = 2'd1;
    localparam logic [1:0] ENDING_CRLF = 2'd2;

    localparam int          ADDR_W     = 4;
    localparam logic [1:0]  REG_SOURCE = 2'd0;
    localparam logic [1:0]  REG_DEST   = 2'd1;
    localparam logic [1:0]  REG_SWAP   = 2'd2;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        end_of_stream;
    } item_t;

    typedef struct packed {
        logic [15:0] out_unit;
        logic        last_of_run;
    } result_t;

    typedef struct packed {
        logic [1:0] source_ending;
        logic [1:0] dest_ending;
        logic       swap_order;
    } cfg_t;

    typedef struct packed {
        logic        mark_seen;
        logic        big_endian_source;
        logic [15:0] held_unit;
        logic        held_valid;
        logic        after_line_end;
    } conv_state_t;

    function automatic logic [15:0] flip_bytes(input logic [15:0] v);
        return {v[7:0], v[15:8]};
    endfunction

endpackage

### hw/rtl/utf16_line_ending_converter.sv
// ----------------------------------------------------------------------------
// utf16_line_ending_converter
// Results are registered and appear in the cycle after a unit is accepted;
// with a CR LF source each unit is held until the next unit or end of stream.
// Throughput: one unit per cycle while result_stall is low; a unit that expands
// to two results stalls the input while the second result drains.
// Reset: rst_n clears configuration and stream state and empties the output buffer.
// ----------------------------------------------------------------------------
module utf16_line_ending_converter
    import ule_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              item_valid,
    output logic              item_stall,
    input  item_t             item,
    output logic              result_valid,
    input  logic              result_stall,
    output result_t           result
);

    cfg_t        cfg_reg;
    conv_state_t state_reg;
    conv_state_t state_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    result_t     slot0_reg;
    result_t     slot0_next;
    result_t     slot1_reg;
    result_t     slot1_next;
    logic [1:0]  res_count;
    result_t     res0;
    result_t     res1;
    logic        take;
    logic        pop;
    logic        cfg_write;

    ule_step u_step (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .item       (item),
        .state_next (state_next),
        .res_count  (res_count),
        .res0       (res0),
        .res1       (res1)
    );

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        prdata = '0;
        case (paddr[3:2])
            REG_SOURCE: prdata[1:0] = cfg_reg.source_ending;
            REG_DEST:   prdata[1:0] = cfg_reg.dest_ending;
            REG_SWAP:   prdata[0]   = cfg_reg.swap_order;
            default:    prdata      = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_SOURCE: cfg_reg.source_ending <= pwdata[1:0];
                REG_DEST:   cfg_reg.dest_ending   <= pwdata[1:0];
                REG_SWAP:   cfg_reg.swap_order    <= pwdata[0];
                default:    cfg_reg               <= cfg_reg;
            endcase
        end
    end

    assign result_valid = (count_reg != 2'd0);
    assign result       = slot0_reg;
    assign pop          = result_valid && !result_stall;
    assign item_stall   = !((count_reg == 2'd0) || (count_reg == 2'd1 && !result_stall));
    assign take         = item_valid && !item_stall;

    always_comb
    begin
        count_next = count_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (pop)
        begin
            count_next = count_reg - 2'd1;
            slot0_next = slot1_reg;
        end
        if (take)
        begin
            count_next = res_count;
            slot0_next = res0;
            slot1_next = res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (take)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

### hw/rtl/ule_step.sv
// ----------------------------------------------------------------------------
// ule_step
// Per-unit conversion: line ending detection, replacement and byte swap.
// ----------------------------------------------------------------------------
module ule_step
    import ule_pkg::*;
(
    input  cfg_t        cfg,
    input  conv_state_t state,
    input  item_t       item,
    output conv_state_t state_next,
    output logic [1:0]  res_count,
    output result_t     res0,
    output result_t     res1
);

    logic        big;
    logic [15:0] raw_lf;
    logic [15:0] raw_cr;
    logic [15:0] end0;
    logic [15:0] end1;
    logic [1:0]  end_count;
    logic [15:0] raw0;
    logic [15:0] raw1;
    logic [1:0]  n;
    logic        emit_held;

    always_comb
    begin
        big    = state.mark_seen ? state.big_endian_source
                                 : (item.code_unit == MARK_SWAPPED);
        raw_lf = big ? flip_bytes(LF_CODE) : LF_CODE;
        raw_cr = big ? flip_bytes(CR_CODE) : CR_CODE;

        end0      = raw_lf;
        end1      = raw_lf;
        end_count = 2'd0;
        case (cfg.dest_ending)
            ENDING_LF:
            begin
                end0      = raw_lf;
                end_count = 2'd1;
            end
            ENDING_CR:
            begin
                end0      = raw_cr;
                end_count = 2'd1;
            end
            ENDING_CRLF:
            begin
                end0      = raw_cr;
                end1      = raw_lf;
                end_count = 2'd2;
            end
            default:
            begin
                end_count = 2'd0;
            end
        endcase

        emit_held  = state.held_valid && !state.after_line_end;
        state_next = state;
        raw0       = item.code_unit;
        raw1       = end1;
        n          = 2'd0;

        if (item.end_of_stream)
        begin
            raw0       = state.held_unit;
            n          = emit_held ? 2'd1 : 2'd0;
            state_next = '0;
        end
        else
        begin
            state_next.mark_seen         = 1'b1;
            state_next.big_endian_source = big;
            case (cfg.source_ending)
                ENDING_CRLF:
                begin
                    if (state.held_valid && state.held_unit == raw_cr
                        && item.code_unit == raw_lf)
                    begin
                        state_next.after_line_end = 1'b1;
                        raw0 = end0;
                        n    = end_count;
                    end
                    else
                    begin
                        state_next.after_line_end = 1'b0;
                        raw0 = state.held_unit;
                        n    = emit_held ? 2'd1 : 2'd0;
                    end
                    state_next.held_unit  = item.code_unit;
                    state_next.held_valid = 1'b1;
                end
                ENDING_LF:
                begin
                    if (item.code_unit == raw_lf)
                    begin
                        raw0 = end0;
                        n    = end_count;
                    end
                    else
                    begin
                        n = 2'd1;
                    end
                end
                ENDING_CR:
                begin
                    if (item.code_unit == raw_cr)
                    begin
                        raw0 = end0;
                        n    = end_count;
                    end
                    else
                    begin
                        n = 2'd1;
                    end
                end
                default:
                begin
                    n = 2'd0;
                end
            endcase
        end

        res_count        = n;
        res0.out_unit    = cfg.swap_order ? flip_bytes(raw0) : raw0;
        res0.last_of_run = (n == 2'd1);
        res1.out_unit    = cfg.swap_order ? flip_bytes(raw1) : raw1;
        res1.last_of_run = 1'b1;
    end

endmodule
